// File: src/small_32bit_instruction_executor_top_macros.svh
// Assertion macros shared by the executor RTL.
`ifndef SMALL_32BIT_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define SMALL_32BIT_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define S32IE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("s32ie assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define S32IE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("s32ie assertion failed");
`else
`define S32IE_ASSERT_IMPL(lbl, ante, cons)
`define S32IE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/s32ie_pkg.sv
// Types, codes and constants shared by the executor modules.
package s32ie_pkg;

  localparam int unsigned MemAddrBitsDef = 16;

  // Item opcodes.
  localparam logic [1:0] OPC_EXEC  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  // Instruction classes.
  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_SWI   = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_JMP   = 4'h3;
  localparam logic [3:0] OP_XCHG  = 4'h4;
  localparam logic [3:0] OP_ARITH = 4'h5;
  localparam logic [3:0] OP_LOGIC = 4'h6;
  localparam logic [3:0] OP_SHIFT = 4'h7;
  localparam logic [3:0] OP_STORE = 4'h8;
  localparam logic [3:0] OP_LOAD  = 4'h9;

  // Modes.
  localparam logic [3:0] M_CALL_IND = 4'd1;
  localparam logic [3:0] M_ADD      = 4'd0;
  localparam logic [3:0] M_SUB      = 4'd1;
  localparam logic [3:0] M_MUL      = 4'd2;
  localparam logic [3:0] M_DIV      = 4'd3;
  localparam logic [3:0] M_NOT      = 4'd0;
  localparam logic [3:0] M_AND      = 4'd1;
  localparam logic [3:0] M_OR       = 4'd2;
  localparam logic [3:0] M_XOR      = 4'd3;
  localparam logic [3:0] M_SHL      = 4'd0;
  localparam logic [3:0] M_ST_IDX   = 4'd0;
  localparam logic [3:0] M_ST_PRE   = 4'd1;
  localparam logic [3:0] M_ST_IND   = 4'd2;
  localparam logic [3:0] M_LD_CTRL  = 4'd0;
  localparam logic [3:0] M_LD_IMM   = 4'd1;
  localparam logic [3:0] M_LD_IDX   = 4'd2;
  localparam logic [3:0] M_LD_POST  = 4'd3;
  localparam logic [3:0] M_CW_REG   = 4'd4;
  localparam logic [3:0] M_CW_OR    = 4'd5;
  localparam logic [3:0] M_CW_IDX   = 4'd6;
  localparam logic [3:0] M_CW_POST  = 4'd7;

  // Jump conditions (low two mode bits).
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_EQ     = 2'd1;
  localparam logic [1:0] COND_NE     = 2'd2;

  // Register indexes and control registers.
  localparam logic [3:0]  REG_ZERO   = 4'd0;
  localparam logic [3:0]  REG_SP     = 4'd14;
  localparam logic [3:0]  REG_PC     = 4'd15;
  localparam logic [31:0] PC_RESET   = 32'h4000_0000;
  localparam int unsigned NumCtrl    = 3;
  localparam logic [1:0]  CR_STATUS  = 2'd0;
  localparam logic [1:0]  CR_HANDLER = 2'd1;
  localparam logic [1:0]  CR_CAUSE   = 2'd2;
  localparam logic [31:0] CAUSE_SWI  = 32'd4;
  localparam logic [31:0] STATUS_IE  = 32'h1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] mem_address;
    logic [31:0] write_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc_value;
    logic        halted;
    logic [31:0] read_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ACT_NOP, ACT_RD, ACT_WR, ACT_CWR, ACT_LD, ACT_ST, ACT_CALC, ACT_TRAP, ACT_STOP, ACT_END
  } act_e;

  typedef enum logic [1:0] {SL_A, SL_B, SL_C, SL_S} slot_e;

  // One step of an instruction's sequence.
  typedef struct packed {
    act_e        act;
    logic [3:0]  idx;
    slot_e       slot;
    logic [31:0] val;
    logic [31:0] addr;
  } step_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// File: src/s32ie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module s32ie_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned ADDR_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/s32ie_div.sv
// Iterative signed divider, one quotient bit per cycle.
module s32ie_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s32ie_pkg::div_req_t  req_i,
  output logic                 done_o,
  output logic [31:0]          quo_o
);
  import s32ie_pkg::*;

  logic        busy_q, done_q, neg_q, zero_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, mb_q;
  logic [31:0] ma, mb;
  logic [32:0] rem_sh, diff;

  // Operand magnitudes and one restoring step.
  always_comb begin
    ma     = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
    mb     = req_i.divisor[31] ? (32'd0 - req_i.divisor) : req_i.divisor;
    rem_sh = {rem_q, quo_q[31]};
    diff   = rem_sh - {1'b0, mb_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      zero_q <= 1'b0;
      rem_q  <= '0;
      quo_q  <= '0;
      mb_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= ma;
        mb_q   <= mb;
        neg_q  <= req_i.dividend[31] ^ req_i.divisor[31];
        zero_q <= (req_i.divisor == 32'd0);
      end else if (busy_q) begin
        if (!diff[32]) begin
          rem_q <= diff[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Sign fix and the divide-by-zero result.
  assign done_o = done_q;
  assign quo_o  = zero_q ? 32'd0 : (neg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// File: src/small_32bit_instruction_executor_top.sv
// Top level of the 32-bit instruction executor.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (opcode, address, word)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (pc, halted, read word)
//
// A memory word item moves one byte per cycle: memory is byte wide.
// An execute item fetches the instruction word, then decodes it, reads registers,
// stores and loads data words, and for a divide waits on the divider; an unused op
// ends after its decode, and once halted an execute item only returns a result.
// After reset the byte memory is cleared, one byte a cycle, all 2^MEM_ADDR_BITS bytes
// (65536 by default); no item is taken meanwhile.
// A new item is taken while an earlier result still waits on a stalled output.
`include "small_32bit_instruction_executor_top_macros.svh"
module small_32bit_instruction_executor_top #(
  parameter int unsigned MEM_ADDR_BITS = s32ie_pkg::MemAddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  s32ie_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output s32ie_pkg::out_item_t out_item_o
);
  import s32ie_pkg::*;

  localparam logic [2:0] ST_CLR     = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MEM     = 3'd2;
  localparam logic [2:0] ST_FETCHED = 3'd3;
  localparam logic [2:0] ST_EXEC    = 3'd4;
  localparam logic [2:0] ST_RCAP    = 3'd5;
  localparam logic [2:0] ST_DIV     = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  localparam logic [1:0] KIND_ITEM  = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  logic [2:0]  state_q, state_d;
  logic [2:0]  ph_q, ph_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  kind_q, kind_d;
  logic        mwr_q, mwr_d;
  logic [31:0] maddr_q, maddr_d;
  logic [31:0] mdat_q, mdat_d;
  logic [31:0] pc_q, pc_d;
  logic        halted_q, halted_d;
  logic        rd_item_q, rd_item_d;
  logic [15:0] gvalid_q, gvalid_d;
  logic [31:0] ctrl_q [NumCtrl];
  logic [31:0] ctrl_d [NumCtrl];
  logic [MEM_ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [31:0] ins_q, va_q, vb_q, vc_q, vs_q, vr_q;

  logic                     mem_we, mem_done;
  logic [MEM_ADDR_BITS-1:0] mem_waddr, mem_raddr, addr_lo;
  logic [7:0]               mem_wdata, mem_rdata;
  logic                     grf_we;
  logic [3:0]               grf_waddr, grf_raddr;
  logic [31:0]              grf_wdata, grf_rdata;
  div_req_t                 div_req;
  logic                     div_done;
  logic [31:0]              div_quo;
  logic                     rcap, vr_load, vr_div, load_out;

  // Instruction fields.
  logic [3:0]  op_w, m_w, ra, rb, rc;
  logic [31:0] imm, sum_abd, sum_bcd, crd_b, alu_res, rval;
  logic        take, jmp_plain, jmp_mem;
  step_t       st;

  assign op_w      = ins_q[7:4];
  assign m_w       = ins_q[3:0];
  assign ra        = ins_q[15:12];
  assign rb        = ins_q[11:8];
  assign rc        = ins_q[23:20];
  assign imm       = {{20{ins_q[19]}}, ins_q[19:16], ins_q[31:24]};
  assign sum_abd   = va_q + vb_q + imm;
  assign sum_bcd   = vb_q + vc_q + imm;
  assign crd_b     = (rb < 4'(NumCtrl)) ? ctrl_q[rb[1:0]] : 32'd0;
  assign jmp_plain = (m_w[3:2] == 2'b00);
  assign jmp_mem   = (m_w[3:2] == 2'b10);

  // Jump condition on the B and C operands.
  always_comb begin
    case (m_w[1:0])
      COND_ALWAYS: take = 1'b1;
      COND_EQ:     take = (vb_q == vc_q);
      COND_NE:     take = (vb_q != vc_q);
      default:     take = ($signed(vb_q) > $signed(vc_q));
    endcase
  end

  // Arithmetic, logic and shift results; the product is registered in vr_q.
  always_comb begin
    alu_res = vb_q + vc_q;
    case (op_w)
      OP_ARITH: begin
        case (m_w)
          M_SUB:   alu_res = vb_q - vc_q;
          M_MUL:   alu_res = vb_q * vc_q;
          default: alu_res = vb_q + vc_q;
        endcase
      end
      OP_LOGIC: begin
        case (m_w)
          M_NOT:   alu_res = ~vb_q;
          M_AND:   alu_res = vb_q & vc_q;
          M_OR:    alu_res = vb_q | vc_q;
          default: alu_res = vb_q ^ vc_q;
        endcase
      end
      default: begin
        if (m_w == M_SHL) begin
          alu_res = (|vc_q[31:5]) ? 32'd0 : (vb_q << vc_q[4:0]);
        end else begin
          alu_res = (|vc_q[31:5]) ? {32{vb_q[31]}} : 32'($signed(vb_q) >>> vc_q[4:0]);
        end
      end
    endcase
  end

  // Step sequencer: what each instruction does at each phase.
  always_comb begin
    st.act  = ACT_END;
    st.idx  = REG_ZERO;
    st.slot = SL_A;
    st.val  = '0;
    st.addr = '0;
    unique case (op_w)
      OP_HALT: begin
        if (ph_q == 3'd0) st.act = ACT_STOP;
      end
      OP_SWI: begin
        case (ph_q)
          3'd0: begin st.act = ACT_RD; st.idx = REG_SP; st.slot = SL_S; end
          3'd1: begin st.act = ACT_WR; st.idx = REG_SP; st.val = vs_q - 32'd4; end
          3'd2: begin st.act = ACT_ST; st.addr = vs_q - 32'd4; st.val = ctrl_q[CR_STATUS]; end
          3'd3: begin st.act = ACT_WR; st.idx = REG_SP; st.val = vs_q - 32'd8; end
          3'd4: begin st.act = ACT_ST; st.addr = vs_q - 32'd8; st.val = pc_q; end
          3'd5: st.act = ACT_TRAP;
          default: ;
        endcase
      end
      OP_CALL: begin
        case (ph_q)
          3'd0: begin st.act = ACT_RD; st.idx = REG_SP; st.slot = SL_S; end
          3'd1: begin st.act = ACT_WR; st.idx = REG_SP; st.val = vs_q - 32'd4; end
          3'd2: begin st.act = ACT_ST; st.addr = vs_q - 32'd4; st.val = pc_q; end
          3'd3: begin st.act = ACT_RD; st.idx = ra; st.slot = SL_A; end
          3'd4: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
          3'd5: begin
            st.act  = (m_w == M_CALL_IND) ? ACT_LD : ACT_NOP;
            st.addr = sum_abd;
          end
          3'd6: begin
            st.act = ACT_WR;
            st.idx = REG_PC;
            st.val = (m_w == M_CALL_IND) ? mdat_q : sum_abd;
          end
          default: ;
        endcase
      end
      OP_JMP: begin
        case (ph_q)
          3'd0: begin st.act = ACT_RD; st.idx = ra; st.slot = SL_A; end
          3'd1: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
          3'd2: begin st.act = ACT_RD; st.idx = rc; st.slot = SL_C; end
          3'd3: begin
            st.idx  = REG_PC;
            st.val  = va_q + imm;
            st.addr = va_q + imm;
            if (take && jmp_plain) st.act = ACT_WR;
            else if (take && jmp_mem) st.act = ACT_LD;
            else st.act = ACT_NOP;
          end
          3'd4: begin
            st.act = (take && jmp_mem) ? ACT_WR : ACT_NOP;
            st.idx = REG_PC;
            st.val = mdat_q;
          end
          default: ;
        endcase
      end
      OP_XCHG: begin
        case (ph_q)
          3'd0: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
          3'd1: begin st.act = ACT_RD; st.idx = rc; st.slot = SL_C; end
          3'd2: begin st.act = ACT_WR; st.idx = rb; st.val = vc_q; end
          3'd3: begin st.act = ACT_WR; st.idx = rc; st.val = vb_q; end
          default: ;
        endcase
      end
      OP_ARITH, OP_LOGIC, OP_SHIFT: begin
        if ((op_w == OP_SHIFT) || (m_w <= M_DIV)) begin
          case (ph_q)
            3'd0: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
            3'd1: begin st.act = ACT_RD; st.idx = rc; st.slot = SL_C; end
            3'd2: st.act = ACT_CALC;
            3'd3: begin st.act = ACT_WR; st.idx = ra; st.val = vr_q; end
            default: ;
          endcase
        end
      end
      OP_STORE: begin
        if (m_w <= M_ST_IND) begin
          case (ph_q)
            3'd0: begin st.act = ACT_RD; st.idx = ra; st.slot = SL_A; end
            3'd1: begin
              st.act = (m_w == M_ST_PRE) ? ACT_WR : ACT_NOP;
              st.idx = ra;
              st.val = va_q + imm;
            end
            3'd2: begin
              st.act  = (m_w == M_ST_PRE) ? ACT_RD : ACT_NOP;
              st.idx  = ra;
              st.slot = SL_A;
            end
            3'd3: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
            3'd4: begin st.act = ACT_RD; st.idx = rc; st.slot = SL_C; end
            3'd5: begin
              st.act  = (m_w == M_ST_IND) ? ACT_LD : ACT_NOP;
              st.addr = sum_abd;
            end
            3'd6: begin
              st.act = ACT_ST;
              st.val = vc_q;
              case (m_w)
                M_ST_IDX: st.addr = sum_abd;
                M_ST_PRE: st.addr = va_q;
                default:  st.addr = mdat_q;
              endcase
            end
            default: ;
          endcase
        end
      end
      OP_LOAD: begin
        if (m_w <= M_CW_POST) begin
          case (ph_q)
            3'd0: begin st.act = ACT_RD; st.idx = rb; st.slot = SL_B; end
            3'd1: begin st.act = ACT_RD; st.idx = rc; st.slot = SL_C; end
            3'd2: begin
              st.act  = ACT_NOP;
              st.addr = sum_bcd;
              if (m_w == M_LD_IDX || m_w == M_CW_IDX) begin
                st.act = ACT_LD;
              end else if (m_w == M_LD_POST || m_w == M_CW_POST) begin
                st.act  = ACT_LD;
                st.addr = vb_q;
              end
            end
            3'd3: begin
              st.idx = ra;
              st.act = m_w[2] ? ACT_CWR : ACT_WR;
              case (m_w)
                M_LD_CTRL: st.val = crd_b;
                M_LD_IMM:  st.val = vb_q + imm;
                M_CW_REG:  st.val = vb_q;
                M_CW_OR:   st.val = crd_b | imm;
                default:   st.val = mdat_q;
              endcase
            end
            3'd4: begin
              st.act  = (m_w[1:0] == 2'd3) ? ACT_RD : ACT_NOP;
              st.idx  = rb;
              st.slot = SL_B;
            end
            3'd5: begin
              st.act = (m_w[1:0] == 2'd3) ? ACT_WR : ACT_NOP;
              st.idx = rb;
              st.val = vb_q + imm;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Byte address of the current memory word access, wrapped to the memory size.
  assign addr_lo = maddr_q[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(cnt_q);

  // Register read result: r0 is zero, r15 is the pc, unwritten entries read zero.
  assign rval = (st.idx == REG_ZERO) ? 32'd0 :
                (st.idx == REG_PC) ? pc_q :
                (gvalid_q[st.idx] ? grf_rdata : 32'd0);

  // Main control: clearing pass, item intake, byte engine and step execution.
  always_comb begin
    state_d          = state_q;
    ph_d             = ph_q;
    cnt_d            = cnt_q;
    kind_d           = kind_q;
    mwr_d            = mwr_q;
    maddr_d          = maddr_q;
    mdat_d           = mdat_q;
    pc_d             = pc_q;
    halted_d         = halted_q;
    rd_item_d        = rd_item_q;
    gvalid_d         = gvalid_q;
    ctrl_d           = ctrl_q;
    clr_cnt_d        = clr_cnt_q;
    out_d            = out_q;
    mem_we           = 1'b0;
    mem_done         = 1'b0;
    mem_waddr        = addr_lo;
    mem_wdata        = mdat_q[{cnt_q[1:0], 3'b000} +: 8];
    mem_raddr        = addr_lo;
    grf_we           = 1'b0;
    grf_waddr        = st.idx;
    grf_wdata        = st.val;
    grf_raddr        = st.idx;
    div_req.start    = 1'b0;
    div_req.dividend = vb_q;
    div_req.divisor  = vc_q;
    rcap             = 1'b0;
    vr_load          = 1'b0;
    vr_div           = 1'b0;
    load_out         = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + MEM_ADDR_BITS'(1);
        if (clr_cnt_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_item_d = (in_item_i.opcode == OPC_READ);
          maddr_d   = in_item_i.mem_address;
          mdat_d    = in_item_i.write_word;
          cnt_d     = '0;
          kind_d    = KIND_ITEM;
          unique case (in_item_i.opcode)
            OPC_WRITE: begin mwr_d = 1'b1; state_d = ST_MEM; end
            OPC_READ:  begin mwr_d = 1'b0; state_d = ST_MEM; end
            OPC_EXEC: begin
              if (!halted_q) begin
                maddr_d = pc_q;
                mwr_d   = 1'b0;
                kind_d  = KIND_FETCH;
                state_d = ST_MEM;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MEM: begin
        cnt_d = cnt_q + 3'd1;
        if (mwr_q) begin
          mem_we = 1'b1;
          if (cnt_q == 3'd3) mem_done = 1'b1;
        end else begin
          if (cnt_q != 3'd0) mdat_d = {mem_rdata, mdat_q[31:8]};
          if (cnt_q == 3'd4) mem_done = 1'b1;
        end
        if (mem_done) begin
          case (kind_q)
            KIND_ITEM:  state_d = ST_DONE;
            KIND_FETCH: state_d = ST_FETCHED;
            default: begin
              ph_d    = ph_q + 3'd1;
              state_d = ST_EXEC;
            end
          endcase
        end
      end
      ST_FETCHED: begin
        pc_d    = pc_q + 32'd4;
        ph_d    = '0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (st.act)
          ACT_NOP: ph_d = ph_q + 3'd1;
          ACT_RD:  state_d = ST_RCAP;
          ACT_WR: begin
            ph_d = ph_q + 3'd1;
            if (st.idx == REG_PC) begin
              pc_d = st.val;
            end else if (st.idx != REG_ZERO) begin
              grf_we           = 1'b1;
              gvalid_d[st.idx] = 1'b1;
            end
          end
          ACT_CWR: begin
            ph_d = ph_q + 3'd1;
            if (st.idx < 4'(NumCtrl)) ctrl_d[st.idx[1:0]] = st.val;
          end
          ACT_LD, ACT_ST: begin
            maddr_d = st.addr;
            mdat_d  = st.val;
            mwr_d   = (st.act == ACT_ST);
            cnt_d   = '0;
            kind_d  = KIND_EXEC;
            state_d = ST_MEM;
          end
          ACT_CALC: begin
            if (op_w == OP_ARITH && m_w == M_DIV) begin
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end else begin
              vr_load = 1'b1;
              ph_d    = ph_q + 3'd1;
            end
          end
          ACT_TRAP: begin
            ctrl_d[CR_CAUSE]  = CAUSE_SWI;
            ctrl_d[CR_STATUS] = ctrl_q[CR_STATUS] & ~STATUS_IE;
            pc_d              = ctrl_q[CR_HANDLER];
            ph_d              = ph_q + 3'd1;
          end
          ACT_STOP: begin
            halted_d = 1'b1;
            ph_d     = ph_q + 3'd1;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RCAP: begin
        rcap    = 1'b1;
        ph_d    = ph_q + 3'd1;
        state_d = ST_EXEC;
      end
      ST_DIV: begin
        if (div_done) begin
          vr_div  = 1'b1;
          ph_d    = ph_q + 3'd1;
          state_d = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out          = 1'b1;
          out_d.pc_value    = pc_q;
          out_d.halted      = halted_q;
          out_d.read_word   = rd_item_q ? mdat_q : 32'd0;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: filled on a finished item, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ph_q        <= '0;
      cnt_q       <= '0;
      kind_q      <= KIND_ITEM;
      mwr_q       <= 1'b0;
      maddr_q     <= '0;
      mdat_q      <= '0;
      pc_q        <= PC_RESET;
      halted_q    <= 1'b0;
      rd_item_q   <= 1'b0;
      gvalid_q    <= '0;
      ctrl_q      <= '{default: '0};
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      mwr_q       <= mwr_d;
      maddr_q     <= maddr_d;
      mdat_q      <= mdat_d;
      pc_q        <= pc_d;
      halted_q    <= halted_d;
      rd_item_q   <= rd_item_d;
      gvalid_q    <= gvalid_d;
      ctrl_q      <= ctrl_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Operand slots, result and the instruction word.
  always_ff @(posedge clk_i) begin
    if (rcap) begin
      case (st.slot)
        SL_A:    va_q <= rval;
        SL_B:    vb_q <= rval;
        SL_C:    vc_q <= rval;
        default: vs_q <= rval;
      endcase
    end
    if (vr_load) begin
      vr_q <= alu_res;
    end else if (vr_div) begin
      vr_q <= div_quo;
    end
    if (state_q == ST_FETCHED) ins_q <= mdat_q;
  end

  s32ie_ram #(
    .WIDTH    (8),
    .ADDR_BITS(MEM_ADDR_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  s32ie_ram #(
    .WIDTH    (32),
    .ADDR_BITS(4)
  ) u_grf (
    .clk_i  (clk_i),
    .we_i   (grf_we),
    .waddr_i(grf_waddr),
    .wdata_i(grf_wdata),
    .raddr_i(grf_raddr),
    .rdata_o(grf_rdata)
  );

  s32ie_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quo_o (div_quo)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the sequencer.
  `S32IE_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `S32IE_ASSERT_IMPL(a_grf_write_idx, grf_we, (grf_waddr != REG_ZERO) && (grf_waddr != REG_PC))
  `S32IE_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != ST_IDLE)
  `S32IE_ASSERT_IMPL(a_mem_write_src, mem_we && (state_q != ST_CLR), mwr_q && (state_q == ST_MEM))

endmodule

// File: bench/small_32bit_instruction_executor_top_tb.sv
// Self-checking bench for the 32-bit instruction executor: random programs against a predictor.
`timescale 1ns / 100ps
module small_32bit_instruction_executor_top_tb;
  import s32ie_pkg::*;

  localparam logic [1:0] OPC_SPARE = 2'd3;
  localparam logic [1:0] COND_SGT  = 2'd3;
  localparam int unsigned MemBytes = 1 << MemAddrBitsDef;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  small_32bit_instruction_executor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Shadow state of the core.
  logic [31:0] gpr_shadow [16];
  logic [31:0] ctrl_shadow [NumCtrl];
  logic [7:0]  mem_shadow [MemBytes];
  logic        core_stopped;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        error_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

  // Register and memory access helpers of the predictor.
  function automatic logic [31:0] reg_rd(logic [3:0] i);
    return (i == REG_ZERO) ? 32'd0 : gpr_shadow[i];
  endfunction

  function automatic void reg_wr(logic [3:0] i, logic [31:0] v);
    if (i != REG_ZERO) gpr_shadow[i] = v;
  endfunction

  function automatic logic [31:0] ctrl_rd(logic [3:0] i);
    return (i < NumCtrl) ? ctrl_shadow[i[1:0]] : 32'd0;
  endfunction

  function automatic void ctrl_wr(logic [3:0] i, logic [31:0] v);
    if (i < NumCtrl) ctrl_shadow[i[1:0]] = v;
  endfunction

  function automatic logic [31:0] word_load(logic [31:0] addr);
    logic [31:0] v;
    logic [15:0] a;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      a = addr[15:0] + 16'(k);
      v[8*k +: 8] = mem_shadow[a];
    end
    return v;
  endfunction

  function automatic void word_store(logic [31:0] addr, logic [31:0] v);
    logic [15:0] a;
    for (int k = 0; k < 4; k++) begin
      a = addr[15:0] + 16'(k);
      mem_shadow[a] = v[8*k +: 8];
    end
  endfunction

  function automatic void stack_push(logic [31:0] v);
    reg_wr(REG_SP, reg_rd(REG_SP) - 32'd4);
    word_store(reg_rd(REG_SP), v);
  endfunction

  function automatic logic [31:0] signed_div(logic [31:0] a, logic [31:0] b);
    if (b == 32'd0) return 32'd0;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [31:0] shift_right_arith(logic [31:0] a, logic [31:0] s);
    logic signed [31:0] sa;
    sa = a;
    if (s >= 32) return {32{a[31]}};
    return sa >>> s[4:0];
  endfunction

  // Fetch and carry out one instruction on the shadow state.
  function automatic void run_instruction();
    logic [31:0] pc, iw, d, t;
    logic [3:0]  op, m, a, b, c;
    logic        take;
    pc = gpr_shadow[REG_PC];
    iw = word_load(pc);
    op = iw[7:4];
    m  = iw[3:0];
    a  = iw[15:12];
    b  = iw[11:8];
    c  = iw[23:20];
    d  = {{20{iw[19]}}, iw[19:16], iw[31:24]};
    gpr_shadow[REG_PC] = pc + 32'd4;
    case (op)
      OP_HALT: core_stopped = 1'b1;
      OP_SWI: begin
        stack_push(ctrl_shadow[CR_STATUS]);
        stack_push(reg_rd(REG_PC));
        ctrl_shadow[CR_CAUSE] = CAUSE_SWI;
        ctrl_shadow[CR_STATUS] &= ~STATUS_IE;
        reg_wr(REG_PC, ctrl_shadow[CR_HANDLER]);
      end
      OP_CALL: begin
        stack_push(reg_rd(REG_PC));
        if (m == M_CALL_IND) reg_wr(REG_PC, word_load(reg_rd(a) + reg_rd(b) + d));
        else reg_wr(REG_PC, reg_rd(a) + reg_rd(b) + d);
      end
      OP_JMP: begin
        case (m[1:0])
          COND_ALWAYS: take = 1'b1;
          COND_EQ:     take = reg_rd(b) == reg_rd(c);
          COND_NE:     take = reg_rd(b) != reg_rd(c);
          COND_SGT:    take = $signed(reg_rd(b)) > $signed(reg_rd(c));
        endcase
        // Modes 0..3 jump direct, modes 8..11 jump through memory.
        if (take && m[3:2] == 2'b00) reg_wr(REG_PC, reg_rd(a) + d);
        else if (take && m[3:2] == 2'b10) reg_wr(REG_PC, word_load(reg_rd(a) + d));
      end
      OP_XCHG: begin
        t = reg_rd(b);
        reg_wr(b, reg_rd(c));
        reg_wr(c, t);
      end
      OP_ARITH: begin
        case (m)
          M_ADD: reg_wr(a, reg_rd(b) + reg_rd(c));
          M_SUB: reg_wr(a, reg_rd(b) - reg_rd(c));
          M_MUL: reg_wr(a, reg_rd(b) * reg_rd(c));
          M_DIV: reg_wr(a, signed_div(reg_rd(b), reg_rd(c)));
          default: ;
        endcase
      end
      OP_LOGIC: begin
        case (m)
          M_NOT: reg_wr(a, ~reg_rd(b));
          M_AND: reg_wr(a, reg_rd(b) & reg_rd(c));
          M_OR:  reg_wr(a, reg_rd(b) | reg_rd(c));
          M_XOR: reg_wr(a, reg_rd(b) ^ reg_rd(c));
          default: ;
        endcase
      end
      OP_SHIFT: begin
        t = reg_rd(c);
        if (m == M_SHL) reg_wr(a, (t >= 32) ? 32'd0 : reg_rd(b) << t[4:0]);
        else reg_wr(a, shift_right_arith(reg_rd(b), t));
      end
      OP_STORE: begin
        case (m)
          M_ST_IDX: word_store(reg_rd(a) + reg_rd(b) + d, reg_rd(c));
          M_ST_PRE: begin
            reg_wr(a, reg_rd(a) + d);
            word_store(reg_rd(a), reg_rd(c));
          end
          M_ST_IND: word_store(word_load(reg_rd(a) + reg_rd(b) + d), reg_rd(c));
          default: ;
        endcase
      end
      OP_LOAD: begin
        case (m)
          M_LD_CTRL: reg_wr(a, ctrl_rd(b));
          M_LD_IMM:  reg_wr(a, reg_rd(b) + d);
          M_LD_IDX:  reg_wr(a, word_load(reg_rd(b) + reg_rd(c) + d));
          M_LD_POST: begin
            reg_wr(a, word_load(reg_rd(b)));
            reg_wr(b, reg_rd(b) + d);
          end
          M_CW_REG:  ctrl_wr(a, reg_rd(b));
          M_CW_OR:   ctrl_wr(a, ctrl_rd(b) | d);
          M_CW_IDX:  ctrl_wr(a, word_load(reg_rd(b) + reg_rd(c) + d));
          M_CW_POST: begin
            ctrl_wr(a, word_load(reg_rd(b)));
            reg_wr(b, reg_rd(b) + d);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Queue one item and predict its result.
  task automatic send(logic [1:0] opc, logic [31:0] addr, logic [31:0] wv);
    in_item_t  it;
    out_item_t res;
    it.opcode = opc;
    it.mem_address = addr;
    it.write_word = wv;
    res.read_word = '0;
    if (opc == OPC_EXEC) begin
      if (!core_stopped) run_instruction();
    end else if (opc == OPC_WRITE) begin
      word_store(addr, wv);
    end else if (opc == OPC_READ) begin
      res.read_word = word_load(addr);
    end
    res.pc_value = gpr_shadow[REG_PC];
    res.halted = core_stopped;
    pending_items.push_back(it);
    expected_results.push_back(res);
  endtask

  function automatic logic [31:0] encode(logic [3:0] op, logic [3:0] m, logic [3:0] a,
                                         logic [3:0] b, logic [3:0] c, logic [11:0] d);
    return {d[7:0], c, d[11:8], a, b, op, m};
  endfunction

  // Place an instruction at the current pc and execute it.
  task automatic exec_instr(logic [31:0] iw);
    send(OPC_WRITE, gpr_shadow[REG_PC], iw);
    send(OPC_EXEC, $urandom, $urandom);
  endtask

  function automatic logic [31:0] random_instr();
    logic [3:0] op, m;
    op = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'($urandom_range(5, 9));
    m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
    return encode(op, m, 4'($urandom), 4'($urandom), 4'($urandom), 12'($urandom));
  endfunction

  // Stimulus generation.
  initial begin
    int sent;
    int r;
    bit paused;
    for (int k = 0; k < 16; k++) gpr_shadow[k] = '0;
    gpr_shadow[REG_PC] = PC_RESET;
    for (int k = 0; k < NumCtrl; k++) ctrl_shadow[k] = '0;
    for (int k = 0; k < MemBytes; k++) mem_shadow[k] = '0;
    core_stopped = 1'b0;
    paused = 1'b0;

    // Directed: memory extremes, wrap and the spare opcode.
    send(OPC_READ, 32'd0, 32'd0);
    send(OPC_WRITE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send(OPC_READ, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send(OPC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OPC_WRITE, 32'h0000_0100, 32'h8000_0000);
    // Directed: immediate extremes, r0 discard, division and shift corner cases.
    exec_instr(encode(OP_LOAD, M_LD_IMM, 4'd1, REG_ZERO, 4'd0, 12'h800));
    exec_instr(encode(OP_LOAD, M_LD_IMM, REG_ZERO, 4'd1, 4'd0, 12'h7FF));
    exec_instr(encode(OP_LOAD, M_LD_IDX, 4'd2, REG_ZERO, REG_ZERO, 12'h100));
    exec_instr(encode(OP_LOAD, M_LD_IMM, 4'd3, REG_ZERO, 4'd0, 12'hFFF));
    exec_instr(encode(OP_ARITH, M_DIV, 4'd4, 4'd2, 4'd3, 12'h000));
    exec_instr(encode(OP_ARITH, M_DIV, 4'd5, 4'd2, REG_ZERO, 12'h000));
    exec_instr(encode(OP_LOAD, M_LD_IMM, 4'd7, REG_ZERO, 4'd0, 12'd40));
    exec_instr(encode(OP_SHIFT, M_SHL, 4'd6, 4'd3, 4'd7, 12'h000));
    exec_instr(encode(OP_SHIFT, 4'd1, 4'd8, 4'd2, 4'd7, 12'h000));

    // Random: mostly instructions placed at pc, plus memory noise.
    sent = 0;
    while (sent < 830) begin
      if (sent >= 400 && !paused) begin
        paused = 1'b1;
        wait (pending_items.size() == 0);
        wait (expected_results.size() == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 72) begin
        exec_instr(random_instr());
        sent += 2;
      end else if (r < 84) begin
        send(OPC_WRITE, $urandom, $urandom);
        sent++;
      end else if (r < 96) begin
        send(OPC_READ, $urandom, $urandom);
        sent++;
      end else begin
        send(OPC_SPARE, $urandom, $urandom);
        sent++;
      end
    end
    // Halt, then show that execute items do nothing while memory items still work.
    exec_instr(encode(OP_HALT, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                      12'($urandom)));
    send(OPC_EXEC, $urandom, $urandom);
    send(OPC_WRITE, $urandom, $urandom);
    send(OPC_READ, $urandom, $urandom);

    wait (pending_items.size() == 0);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Reset sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Random gap length: mostly short, some long, with calm stretches.
  int calm_left = 0;
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Item driver.
  logic in_taken = 1'b0;
  int   in_gap = 0;
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid && !in_stall;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern.
  int stall_left = 0;
  int flow_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 35) stall_left = pick_gap();
      flow_left = $urandom_range(0, 6);
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result pc", out_item.pc_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.pc_value !== want.pc_value)
          report_mismatch("pc_value", out_item.pc_value, want.pc_value);
        if (out_item.halted !== want.halted)
          report_mismatch("halted", 32'(out_item.halted), 32'(want.halted));
        if (out_item.read_word !== want.read_word)
          report_mismatch("read_word", out_item.read_word, want.read_word);
      end
    end
  end

endmodule
